// ===== src/quoted_printable_encoder_assert.svh =====
// Assertion macros for the encoder modules; the back end includes them.
`ifndef QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`define QUOTED_PRINTABLE_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define QPE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Check that a condition never comes true outside reset.
`define QPE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define QPE_ASSERT(lbl, clk, rst_n, prop)
`define QPE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== src/qpe_pkg.sv =====
// Shared constants, types and helper functions of the Quoted-Printable encoder.
package qpe_pkg;

    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] LIMIT_RESET = 8'd72;
    localparam int         QUEUE_DEPTH = 2;

    // One classified word: up to two units, each with an optional soft break.
    typedef struct packed {
        logic       brk_a;    // soft break before the held-CR unit
        logic       has_a;    // held-CR unit present
        logic       a_lf;     // held CR pairs with LF: emit CR LF
        logic       brk_b;    // soft break before the byte unit
        logic       has_b;    // byte unit present
        logic       plain_b;  // byte passes through literally
        logic [7:0] data;     // source byte
        logic       last;     // final word of the message
    } t_cmd;

    typedef enum logic [1:0] {
        SEG_BRK_A,
        SEG_UNIT_A,
        SEG_BRK_B,
        SEG_UNIT_B
    } t_seg;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] v);
        logic [8:0] s;
        s = {1'b0, a} + {7'd0, v};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

// ===== src/qpe_front.sv =====
// Front end: accepts source words, tracks line count and held CR, classifies.
module qpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_msg_last,
    input  logic          i_line_limit_we,
    input  logic [7:0]    i_line_limit,
    input  logic          i_full,
    output logic          o_push,
    output qpe_pkg::t_cmd o_cmd
);

    logic [7:0] r_line_limit;
    logic [7:0] r_line_count;
    logic       r_cr_pending;
    logic [7:0] n_line_count;
    logic       n_cr_pending;

    logic       accept;
    logic       a_lf;
    logic       brk_a;
    logic       brk_b;
    logic       has_b;
    logic       plain;
    logic [7:0] cnt_a;
    logic [7:0] cnt_mid;
    logic [7:0] cnt_b;
    logic [7:0] cnt_end;

    assign accept = i_in_valid && !i_full;

    always_comb begin
        // Held CR unit first.
        a_lf  = r_cr_pending && (i_in_byte == qpe_pkg::CH_LF);
        brk_a = r_cr_pending && (r_line_count >= r_line_limit);
        cnt_a = brk_a ? 8'd0 : r_line_count;
        if (a_lf) begin
            cnt_mid = 8'd0;
        end else if (r_cr_pending) begin
            cnt_mid = qpe_pkg::sat_add(cnt_a, 2'd3);
        end else begin
            cnt_mid = r_line_count;
        end

        // Then the byte itself, unless it was consumed or is held.
        has_b = !a_lf && !((i_in_byte == qpe_pkg::CH_CR) && !i_msg_last);
        plain = (i_in_byte == qpe_pkg::CH_TAB)
             || ((i_in_byte >= qpe_pkg::CH_SPACE) && (i_in_byte <= qpe_pkg::CH_TILDE)
                 && (i_in_byte != qpe_pkg::CH_EQ));
        brk_b = has_b && (cnt_mid >= r_line_limit);
        cnt_b = brk_b ? 8'd0 : cnt_mid;
        if (has_b) begin
            cnt_end = qpe_pkg::sat_add(cnt_b, plain ? 2'd1 : 2'd3);
        end else begin
            cnt_end = cnt_mid;
        end

        n_line_count = i_msg_last ? 8'd0 : cnt_end;
        n_cr_pending = !a_lf && (i_in_byte == qpe_pkg::CH_CR) && !i_msg_last;

        o_cmd.brk_a   = brk_a;
        o_cmd.has_a   = r_cr_pending;
        o_cmd.a_lf    = a_lf;
        o_cmd.brk_b   = brk_b;
        o_cmd.has_b   = has_b;
        o_cmd.plain_b = plain;
        o_cmd.data    = i_in_byte;
        o_cmd.last    = i_msg_last;

        // A word that only sets the held CR produces nothing.
        o_push = accept && (r_cr_pending || has_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= qpe_pkg::LIMIT_RESET;
            r_line_count <= 8'd0;
            r_cr_pending <= 1'b0;
        end else begin
            if (i_line_limit_we) begin
                r_line_limit <= i_line_limit;
            end
            if (accept) begin
                r_line_count <= n_line_count;
                r_cr_pending <= n_cr_pending;
            end
        end
    end

endmodule

// ===== src/qpe_fifo.sv =====
// Short command queue between front and back ends.
module qpe_fifo #(
    parameter int DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qpe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output qpe_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qpe_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/qpe_back.sv =====
// Back end: expands queued commands into output bytes, one per cycle while the output is not stalled.
`include "quoted_printable_encoder_assert.svh"

module qpe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  qpe_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_msg_end
);

    qpe_pkg::t_cmd r_cmd;
    logic          r_busy;
    logic [3:0]    r_mask;
    logic [1:0]    r_pos;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_run_last;
    logic          r_msg_end;

    logic          n_busy;
    logic [3:0]    n_mask;
    logic [1:0]    n_pos;

    qpe_pkg::t_seg seg;
    logic [1:0]    seg_idx;
    logic [1:0]    seg_len;
    logic [7:0]    cur_byte;
    logic [3:0]    rest_mask;
    logic          seg_end;
    logic          item_end;
    logic          adv;
    logic          emit;

    always_comb begin
        // Pick the lowest segment still to send.
        if (r_mask[0]) begin
            seg = qpe_pkg::SEG_BRK_A;
        end else if (r_mask[1]) begin
            seg = qpe_pkg::SEG_UNIT_A;
        end else if (r_mask[2]) begin
            seg = qpe_pkg::SEG_BRK_B;
        end else begin
            seg = qpe_pkg::SEG_UNIT_B;
        end
        seg_idx = seg;

        case (seg)
            qpe_pkg::SEG_BRK_A, qpe_pkg::SEG_BRK_B: begin
                seg_len  = 2'd3;
                cur_byte = (r_pos == 2'd0) ? qpe_pkg::CH_EQ :
                           (r_pos == 2'd1) ? qpe_pkg::CH_CR : qpe_pkg::CH_LF;
            end
            qpe_pkg::SEG_UNIT_A: begin
                if (r_cmd.a_lf) begin
                    seg_len  = 2'd2;
                    cur_byte = (r_pos == 2'd0) ? qpe_pkg::CH_CR : qpe_pkg::CH_LF;
                end else begin
                    seg_len  = 2'd3;
                    cur_byte = (r_pos == 2'd0) ? qpe_pkg::CH_EQ :
                               (r_pos == 2'd1) ? qpe_pkg::CH_ZERO : qpe_pkg::CH_D;
                end
            end
            qpe_pkg::SEG_UNIT_B: begin
                if (r_cmd.plain_b) begin
                    seg_len  = 2'd1;
                    cur_byte = r_cmd.data;
                end else begin
                    seg_len  = 2'd3;
                    cur_byte = (r_pos == 2'd0) ? qpe_pkg::CH_EQ :
                               (r_pos == 2'd1) ? qpe_pkg::hex_digit(r_cmd.data[7:4]) :
                                                 qpe_pkg::hex_digit(r_cmd.data[3:0]);
                end
            end
            default: begin
                seg_len  = 2'd1;
                cur_byte = r_cmd.data;
            end
        endcase

        rest_mask          = r_mask;
        rest_mask[seg_idx] = 1'b0;
        seg_end            = (r_pos == seg_len - 2'd1);
        item_end           = seg_end && (rest_mask == 4'd0);

        adv   = !r_out_valid || !i_out_stall;
        emit  = adv && r_busy;
        o_pop = !i_empty && (!r_busy || (emit && item_end));

        n_busy = r_busy;
        n_mask = r_mask;
        n_pos  = r_pos;
        if (o_pop) begin
            n_busy = 1'b1;
            n_mask = {i_cmd.has_b, i_cmd.brk_b, i_cmd.has_a, i_cmd.brk_a};
            n_pos  = 2'd0;
        end else if (emit) begin
            if (seg_end) begin
                n_mask = rest_mask;
                n_pos  = 2'd0;
                n_busy = !item_end;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_out_byte <= cur_byte;
            r_run_last <= item_end;
            r_msg_end  <= item_end && r_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= 4'd0;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_mask <= n_mask;
            r_pos  <= n_pos;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_msg_end   = r_msg_end;

    `QPE_ASSERT(a_busy_has_work, i_clk, i_rst_n, r_busy |-> (r_mask != 4'd0))
    `QPE_ASSERT(a_pos_in_segment, i_clk, i_rst_n, r_busy |-> (r_pos < seg_len))
    `QPE_ASSERT(a_end_is_run_last, i_clk, i_rst_n, (r_out_valid && r_msg_end) |-> r_run_last)
    `QPE_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, o_pop && i_empty)

endmodule

// ===== src/quoted_printable_encoder.sv =====
// Top level of the Quoted-Printable encoder: front end, command queue, back end.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in_byte, i_msg_last
//  output    out        o_out_valid / i_out_stall  o_out_byte, o_run_last, o_msg_end
//  config    in         i_line_limit_we            i_line_limit
//
// The front end takes one source word per cycle while the queue has room.
// The back end sends one output byte per cycle unless the output stalls: a
// literal byte gives 1 output byte, an escaped byte 3, a soft break adds 3, a
// held CR adds 2 or 3; a word yields 0 to 12 bytes, setting the sustained rate.
// Reset (synchronous, active low) empties queue and output register, drops a
// held CR, clears the line count and sets the line limit to 72.
// A stalled output holds its byte; the front keeps accepting until the
// queue fills, then raises o_in_stall.
module quoted_printable_encoder #(
    parameter int QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_msg_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_msg_end,
    input  logic       i_line_limit_we,
    input  logic [7:0] i_line_limit
);

    qpe_pkg::t_cmd push_cmd;
    qpe_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // Stall the source only when the queue is full; it comes from a register.
    assign o_in_stall = q_full;

    // Classify each word and track line count and held CR.
    qpe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_msg_last      (i_msg_last),
        .i_line_limit_we (i_line_limit_we),
        .i_line_limit    (i_line_limit),
        .i_full          (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // Decouple the two halves so each can stall on its own.
    qpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Expand commands into encoded bytes behind an output register.
    qpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_msg_end   (o_msg_end)
    );

endmodule
